// ----- hw/rtl/crc16_frame_encoder_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the checker of the frame encoder.
// ---------------------------------------------------------------------------
`ifndef CRC16_FRAME_ENCODER_ASSERT_SVH
`define CRC16_FRAME_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFE_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cfe_pkg.sv -----
// ---------------------------------------------------------------------------
// cfe_pkg
// Types, constants and the CRC step function of the CRC-16 frame encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package cfe_pkg;

  // Input word: one start request or one payload byte.
  typedef struct packed {
    logic        start_req;
    logic [7:0]  message_type;
    logic [7:0]  flag_bits;
    logic [15:0] command_code;
    logic [31:0] sequence_number;
    logic [11:0] payload_length;
    logic [7:0]  data_byte;
  } in_t;

  // Output word: one frame byte or one error report.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] error_code;
  } out_t;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LENGTH   = 2'd1;
  localparam logic [1:0] ERR_NO_FRAME = 2'd2;
  localparam logic [1:0] ERR_IN_FRAME = 2'd3;

  // Kind of work handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_ERR,
    CMD_HDR,
    CMD_DATA
  } kind_e;

  // Queue entry: a classified input word.
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  err;
    logic        has_data;
    logic        close;
    logic [7:0]  message_type;
    logic [7:0]  flag_bits;
    logic [15:0] command_code;
    logic [31:0] sequence_number;
    logic [11:0] payload_length;
    logic [7:0]  data_byte;
  } cmd_t;

  // Byte positions within the work of one queue entry.
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_HDR0     = 5'd0;
  localparam logic [STEP_W-1:0] STEP_HDR_LAST = 5'd15;
  localparam logic [STEP_W-1:0] STEP_DATA     = 5'd16;
  localparam logic [STEP_W-1:0] STEP_CRC_LO   = 5'd17;
  localparam logic [STEP_W-1:0] STEP_CRC_HI   = 5'd18;

  // Header constants.
  localparam logic [7:0] MAGIC_0     = 8'hAA;
  localparam logic [7:0] MAGIC_1     = 8'h55;
  localparam logic [7:0] HEADER_SIZE = 8'd16;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Version register reset value.
  localparam logic [7:0] VERSION_RESET = 8'd1;

  // Fold one byte into the CRC, MSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crc16_frame_encoder.sv -----
// ---------------------------------------------------------------------------
// crc16_frame_encoder
// Builds framed packets with a 16-byte header and a trailing CRC-16.
// ---------------------------------------------------------------------------
// Input words arrive on in_valid_i/in_stall_o. A start word opens a frame and
// yields the 16 header bytes, then the first payload byte if the length is not
// zero; each later word yields one payload byte. The last payload byte is
// followed by the CRC-16/CCITT-FALSE of the frame, low byte first. Misuse
// gives one error word with out_byte zero. Output words leave on
// out_valid_o/out_stall_i; last_byte marks the final output of an input word.
// The first output of a word goes through the queue and the output register.
// Payload words that do not close the frame stream at one per cycle while the
// output is not stalled; a start word holds the output sequencer for its header
// bytes, which it emits one per cycle unless the output is stalled. A two-entry queue
// between the classifier and the sequencer keeps input accepted while output
// is stalled, until the queue fills. Reset closes any frame, empties the queue
// and sets the version register to 1. The version register lies at address 0
// of the APB port.
// ---------------------------------------------------------------------------
`default_nettype none

module crc16_frame_encoder
  import cfe_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 2048,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output logic              in_stall_o,
  input  wire  in_t         in_data_i,
  output logic              out_valid_o,
  input  wire  logic        out_stall_i,
  output out_t              out_data_o,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [2:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0] version_q;
  logic       q_full, q_push, q_pop, q_valid;
  cmd_t       q_in, q_head;
  logic       reg_sel;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {24'b0, version_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VERSION_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      version_q <= pwdata[7:0];
    end
  end

  // Front end: classify input words.
  cfe_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (q_in)
  );

  // Queue between front and back.
  cfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Back end: emit frame bytes.
  cfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .version_i    (version_q),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/cfe_queue.sv -----
// ---------------------------------------------------------------------------
// cfe_queue
// Short first-in first-out queue of classified words between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module cfe_queue
  import cfe_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic push_i,
  input  wire  cmd_t push_data_i,
  output logic       full_o,
  input  wire  logic pop_i,
  output logic       valid_o,
  output cmd_t       head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cfe_front.sv -----
// ---------------------------------------------------------------------------
// cfe_front
// Accepts input words, tracks the open frame and classifies each word.
// ---------------------------------------------------------------------------
`default_nettype none

module cfe_front
  import cfe_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 2048
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_stall_o,
  input  wire  in_t  in_data_i,
  input  wire  logic q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic        frame_open_q, frame_open_d;
  logic [11:0] bytes_left_q, bytes_left_d;
  logic        too_long;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign too_long   = ({4'b0, in_data_i.payload_length} > 16'(MAX_PAYLOAD));

  // Classify the word and work out the frame state after it.
  always_comb begin
    frame_open_d          = frame_open_q;
    bytes_left_d          = bytes_left_q;
    cmd_o.kind            = CMD_ERR;
    cmd_o.err             = ERR_NONE;
    cmd_o.has_data        = 1'b0;
    cmd_o.close           = 1'b0;
    cmd_o.message_type    = in_data_i.message_type;
    cmd_o.flag_bits       = in_data_i.flag_bits;
    cmd_o.command_code    = in_data_i.command_code;
    cmd_o.sequence_number = in_data_i.sequence_number;
    cmd_o.payload_length  = in_data_i.payload_length;
    cmd_o.data_byte       = in_data_i.data_byte;
    if (in_data_i.start_req) begin
      if (frame_open_q) begin
        cmd_o.err = ERR_IN_FRAME;
      end else if (too_long) begin
        cmd_o.err = ERR_LENGTH;
      end else begin
        cmd_o.kind     = CMD_HDR;
        cmd_o.has_data = (in_data_i.payload_length != '0);
        cmd_o.close    = (in_data_i.payload_length <= 12'd1);
        frame_open_d   = (in_data_i.payload_length > 12'd1);
        bytes_left_d   = in_data_i.payload_length - 1'b1;
      end
    end else if (!frame_open_q) begin
      cmd_o.err = ERR_NO_FRAME;
    end else begin
      cmd_o.kind     = CMD_DATA;
      cmd_o.has_data = 1'b1;
      cmd_o.close    = (bytes_left_q == 12'd1);
      frame_open_d   = (bytes_left_q != 12'd1);
      bytes_left_d   = bytes_left_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= '0;
    end else if (push_o) begin
      frame_open_q <= frame_open_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cfe_back.sv -----
// ---------------------------------------------------------------------------
// cfe_back
// Sequences header, payload and CRC bytes of each queued word into the output.
// ---------------------------------------------------------------------------
`default_nettype none

module cfe_back
  import cfe_pkg::*;
(
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic [7:0] version_i,
  input  wire  logic       head_valid_i,
  input  wire  cmd_t       head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire  logic       out_stall_i,
  output out_t             out_data_o
);

  logic              out_valid_q;
  out_t              out_q;
  logic [15:0]       crc_q;
  logic              busy_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] step;
  logic [7:0]        hdr [16];
  logic [15:0]       crc_base;
  logic              advance, fire, done;
  out_t              res;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = advance && head_valid_i;
  assign pop_o       = fire && done;

  // Current byte position; a new payload word starts at the data position.
  assign step = busy_q ? step_q : ((head_i.kind == CMD_DATA) ? STEP_DATA : STEP_HDR0);
  assign crc_base = (step == STEP_HDR0) ? CRC_INIT : crc_q;

  // Header bytes of the word at the head.
  always_comb begin
    hdr[0]  = MAGIC_0;
    hdr[1]  = MAGIC_1;
    hdr[2]  = version_i;
    hdr[3]  = HEADER_SIZE;
    hdr[4]  = head_i.message_type;
    hdr[5]  = head_i.flag_bits;
    hdr[6]  = head_i.command_code[7:0];
    hdr[7]  = head_i.command_code[15:8];
    hdr[8]  = head_i.sequence_number[7:0];
    hdr[9]  = head_i.sequence_number[15:8];
    hdr[10] = head_i.sequence_number[23:16];
    hdr[11] = head_i.sequence_number[31:24];
    hdr[12] = head_i.payload_length[7:0];
    hdr[13] = {4'b0, head_i.payload_length[11:8]};
    hdr[14] = 8'h00;
    hdr[15] = 8'h00;
  end

  // Result byte, end-of-word flag and next position.
  always_comb begin
    res.out_byte   = 8'h00;
    res.last_byte  = 1'b0;
    res.error_code = ERR_NONE;
    done           = 1'b0;
    step_d         = step + 1'b1;
    if (head_i.kind == CMD_ERR) begin
      res.last_byte  = 1'b1;
      res.error_code = head_i.err;
      done           = 1'b1;
    end else if (step < STEP_DATA) begin
      res.out_byte = hdr[step[3:0]];
      if (step == STEP_HDR_LAST) begin
        step_d = head_i.has_data ? STEP_DATA : STEP_CRC_LO;
      end
    end else if (step == STEP_DATA) begin
      res.out_byte  = head_i.data_byte;
      res.last_byte = !head_i.close;
      done          = !head_i.close;
    end else if (step == STEP_CRC_LO) begin
      res.out_byte = crc_q[7:0];
    end else begin
      res.out_byte  = crc_q[15:8];
      res.last_byte = 1'b1;
      done          = 1'b1;
    end
  end

  // Sequencer and CRC state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= CRC_INIT;
      busy_q      <= 1'b0;
      step_q      <= STEP_HDR0;
    end else begin
      if (advance) begin
        out_valid_q <= fire;
      end
      if (fire) begin
        busy_q <= !done;
        step_q <= step_d;
        if (head_i.kind != CMD_ERR) begin
          if (step <= STEP_DATA) begin
            crc_q <= crc16_byte(crc_base, res.out_byte);
          end else if (step == STEP_CRC_HI) begin
            crc_q <= CRC_INIT;
          end
        end
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cfe_checker.sv -----
// ---------------------------------------------------------------------------
// cfe_checker
// Port-level checks of the frame encoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "crc16_frame_encoder_assert.svh"

module cfe_checker
  import cfe_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire in_t         in_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire out_t        out_data_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // A stalled output word holds.
  `CFE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "output word changed while stalled")

  // A stalled input word holds.
  `CFE_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i), "input word changed while stalled")

  // An error report is a single, final, zero byte.
  `CFE_ASSERT_SAME(a_err_shape, clk_i, rst_ni, out_valid_o && (out_data_o.error_code != ERR_NONE), out_data_o.last_byte && (out_data_o.out_byte == 8'h00), "malformed error word")

  // A version write reads back in the next cycle.
  `CFE_ASSERT_NEXT(a_cfg_readback, clk_i, rst_ni, psel && penable && pwrite && pready && (paddr[2] == 1'b0), prdata[7:0] == $past(pwdata[7:0]), "version register readback mismatch")

endmodule

bind crc16_frame_encoder cfe_checker u_cfe_checker (.*);

`default_nettype wire

// ----- sim/crc16_frame_encoder_tb.sv -----
// ---------------------------------------------------------------------------
// crc16_frame_encoder_tb
// Self-checking testbench for the CRC-16 framed packet encoder.
// ---------------------------------------------------------------------------
// A short scripted sequence covers the following cases:
//   - a payload byte with no frame open
//   - zero-length frames
//   - header fields at both extremes
//   - lengths beyond the maximum
//   - a start inside an open frame
//   - frames that close normally
// Random frames with random header contents, plus some misuse words, then run
// under three settings of the version register, the first two with random
// gaps and stalls on both channels. Every output word is checked against a
// behavioral encoder kept in this file. The last frame opens at the largest
// payload length the block allows.
// ---------------------------------------------------------------------------

module crc16_frame_encoder_tb;
  import cfe_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 2048;
  localparam logic [2:0] VERSION_ADDR = 3'd0;

  // One scripted word, with the error result typed in where it is obvious.
  typedef struct packed {
    in_t        word;
    logic       typed;
    logic [1:0] err;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Encoder state as the block should hold it.
  logic [15:0] crc_q;
  logic [11:0] left_q;
  logic        open_q;
  logic [7:0]  version_q;

  // Output words still owed by the block, oldest first.
  out_t bytes_due [$];
  out_t due_now;
  row_t script [$];

  int send_idle_pct;
  int recv_idle_pct;
  int words_sent;
  int frames_built;
  int misuse_words;
  int bytes_checked;
  int mismatches;
  logic [7:0] last_version;

  crc16_frame_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // CRC-16/CCITT-FALSE, one message bit at a time, MSB first.
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc;
    for (k = 7; k >= 0; k--) begin
      if (c[15] ^ b[k]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Work out the output words that one accepted input word causes.
  function automatic void encode_word(input in_t w);
    logic [7:0] burst [0:18];
    logic [7:0] hdr [0:15];
    logic [1:0] err;
    out_t o;
    int n;
    int i;
    n = 0;
    err = ERR_NONE;
    if (w.start_req && open_q) begin
      err = ERR_IN_FRAME;
    end else if (w.start_req && w.payload_length > MAX_PAYLOAD) begin
      err = ERR_LENGTH;
    end else if (!w.start_req && !open_q) begin
      err = ERR_NO_FRAME;
    end else begin
      // A start emits the header and restarts the CRC.
      if (w.start_req) begin
        hdr[0]  = MAGIC_0;
        hdr[1]  = MAGIC_1;
        hdr[2]  = version_q;
        hdr[3]  = HEADER_SIZE;
        hdr[4]  = w.message_type;
        hdr[5]  = w.flag_bits;
        hdr[6]  = w.command_code[7:0];
        hdr[7]  = w.command_code[15:8];
        hdr[8]  = w.sequence_number[7:0];
        hdr[9]  = w.sequence_number[15:8];
        hdr[10] = w.sequence_number[23:16];
        hdr[11] = w.sequence_number[31:24];
        hdr[12] = w.payload_length[7:0];
        hdr[13] = {4'h0, w.payload_length[11:8]};
        hdr[14] = 8'h00;
        hdr[15] = 8'h00;
        crc_q = CRC_INIT;
        for (i = 0; i < 16; i++) begin
          burst[n] = hdr[i];
          crc_q = crc_ccitt_step(crc_q, hdr[i]);
          n++;
        end
        frames_built++;
        if (w.payload_length == 12'd0) begin
          burst[n]     = crc_q[7:0];
          burst[n + 1] = crc_q[15:8];
          n += 2;
          crc_q = CRC_INIT;
        end else begin
          open_q = 1'b1;
          left_q = w.payload_length;
        end
      end
      // One payload byte; the last one closes the frame with the CRC.
      if (open_q) begin
        burst[n] = w.data_byte;
        crc_q = crc_ccitt_step(crc_q, w.data_byte);
        n++;
        left_q = left_q - 12'd1;
        if (left_q == 12'd0) begin
          burst[n]     = crc_q[7:0];
          burst[n + 1] = crc_q[15:8];
          n += 2;
          crc_q = CRC_INIT;
          open_q = 1'b0;
        end
      end
    end
    if (err != ERR_NONE) begin
      burst[0] = 8'h00;
      n = 1;
      misuse_words++;
    end
    for (i = 0; i < n; i++) begin
      o = {burst[i], (i == n - 1), err};
      bytes_due.push_back(o);
    end
  endfunction

  function automatic in_t rand_word();
    in_t w;
    w.start_req       = 1'($urandom_range(1));
    w.message_type    = 8'($urandom);
    w.flag_bits       = 8'($urandom);
    w.command_code    = 16'($urandom);
    w.sequence_number = $urandom;
    w.payload_length  = 12'($urandom);
    w.data_byte       = 8'($urandom);
    return w;
  endfunction

  function automatic in_t start_word(input logic [7:0] mtype, input logic [7:0] flags,
                                     input logic [15:0] cmd, input logic [31:0] seq,
                                     input logic [11:0] len, input logic [7:0] data);
    return {1'b1, mtype, flags, cmd, seq, len, data};
  endfunction

  function automatic in_t byte_word(input logic [7:0] data);
    return {1'b0, 8'h00, 8'h00, 16'h0000, 32'h0, 12'h000, data};
  endfunction

  // Offer one word after a random gap and predict its output once accepted.
  task automatic send_word(input in_t w, input logic typed, input logic [1:0] err);
    int held;
    out_t fixed;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= rand_word();
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    held = bytes_due.size();
    encode_word(w);
    // A typed-in error result replaces the predicted one.
    if (typed) begin
      while (bytes_due.size() > held) begin
        void'(bytes_due.pop_back());
      end
      fixed = {8'h00, 1'b1, err};
      bytes_due.push_back(fixed);
    end
    words_sent++;
  endtask

  // Hold the input channel quiet until every owed word has come out.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bytes_due.size() != 0);
  endtask

  // Write the version register over APB and read it back.
  task automatic write_version(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VERSION_ADDR;
    pwdata  <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    version_q = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== v) begin
      note_mismatch($sformatf("version readback: expected %02h, got %02h", v, prdata[7:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A well-formed frame with random content; now and then a start barges in.
  task automatic send_random_frame(input logic [11:0] len);
    in_t w;
    w = rand_word();
    w.start_req = 1'b1;
    w.payload_length = len;
    send_word(w, 1'b0, ERR_NONE);
    while (open_q) begin
      w = rand_word();
      w.start_req = ($urandom_range(99) < 4);
      send_word(w, 1'b0, ERR_NONE);
    end
  endtask

  // Mostly frames of small size, some misuse words and some full drains.
  task automatic run_random(input int n_words);
    int goal;
    int r;
    logic [11:0] len;
    in_t w;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      r = $urandom_range(99);
      if (r < 3) begin
        drain_block();
      end else if (r < 9) begin
        w = rand_word();
        w.start_req = 1'b0;
        send_word(w, 1'b0, ERR_NONE);
      end else if (r < 14) begin
        w = rand_word();
        w.start_req = 1'b1;
        w.payload_length = 12'($urandom_range(4095, MAX_PAYLOAD + 1));
        send_word(w, 1'b0, ERR_NONE);
      end else begin
        r = $urandom_range(99);
        if (r < 12) begin
          len = 12'd0;
        end else if (r < 80) begin
          len = 12'($urandom_range(8, 1));
        end else if (r < 96) begin
          len = 12'($urandom_range(48, 9));
        end else begin
          len = 12'($urandom_range(300, 49));
        end
        send_random_frame(len);
      end
    end
  endtask

  // Check each output word taken and choose the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_checked++;
      if (bytes_due.size() == 0) begin
        note_mismatch($sformatf("unexpected word: byte %02h last %0b err %0d",
                                out_data_o.out_byte, out_data_o.last_byte,
                                out_data_o.error_code));
      end else begin
        due_now = bytes_due.pop_front();
        if (out_data_o.out_byte !== due_now.out_byte ||
            out_data_o.last_byte !== due_now.last_byte ||
            out_data_o.error_code !== due_now.error_code) begin
          note_mismatch($sformatf(
            "word mismatch: expected byte %02h last %0b err %0d, got byte %02h last %0b err %0d",
            due_now.out_byte, due_now.last_byte, due_now.error_code,
            out_data_o.out_byte, out_data_o.last_byte, out_data_o.error_code));
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    crc_q         = CRC_INIT;
    left_q        = 12'd0;
    open_q        = 1'b0;
    version_q     = VERSION_RESET;
    send_idle_pct = 27;
    recv_idle_pct = 71;
    words_sent    = 0;
    frames_built  = 0;
    misuse_words  = 0;
    bytes_checked = 0;
    mismatches    = 0;
    last_version  = 8'h00;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Scripted words, run with the version register at its reset value.
    script.push_back({byte_word(8'h00), 1'b1, ERR_NO_FRAME});
    script.push_back({start_word(8'h00, 8'h00, 16'h0000, 32'h0000_0000, 12'd0, 8'hFF),
                      1'b0, ERR_NONE});
    script.push_back({start_word(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 12'd0, 8'h00),
                      1'b0, ERR_NONE});
    script.push_back({start_word(8'h01, 8'h02, 16'h0304, 32'h0506_0708,
                                 12'(MAX_PAYLOAD + 1), 8'h00), 1'b1, ERR_LENGTH});
    script.push_back({start_word(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF, 8'hFF),
                      1'b1, ERR_LENGTH});
    script.push_back({start_word(8'h12, 8'h34, 16'hABCD, 32'h0123_4567, 12'd1, 8'hFF),
                      1'b0, ERR_NONE});
    script.push_back({start_word(8'h5A, 8'hA5, 16'h8001, 32'h8000_0001, 12'd3, 8'h00),
                      1'b0, ERR_NONE});
    script.push_back({byte_word(8'h80), 1'b0, ERR_NONE});
    script.push_back({start_word(8'h00, 8'h00, 16'h0000, 32'h0, 12'hFFF, 8'h00),
                      1'b1, ERR_IN_FRAME});
    script.push_back({start_word(8'hC3, 8'h3C, 16'h1234, 32'hDEAD_BEEF, 12'd5, 8'h11),
                      1'b1, ERR_IN_FRAME});
    script.push_back({byte_word(8'h7F), 1'b0, ERR_NONE});
    script.push_back({byte_word(8'hFF), 1'b1, ERR_NO_FRAME});
    script.push_back({start_word(8'h80, 8'h01, 16'h0080, 32'h0000_8000, 12'd2, 8'h01),
                      1'b0, ERR_NONE});
    script.push_back({byte_word(8'hFE), 1'b0, ERR_NONE});
    foreach (script[i]) begin
      send_word(script[i].word, script[i].typed, script[i].err);
    end
    drain_block();

    // Sender idles less than the receiver.
    write_version(8'h00);
    run_random(150);
    drain_block();

    // Receiver idles less than the sender.
    write_version(8'hFF);
    send_idle_pct = 71;
    recv_idle_pct = 27;
    run_random(150);
    drain_block();

    // Neither side idles; finish by opening a frame at the largest length.
    last_version = 8'($urandom);
    write_version(last_version);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(150);
    send_word(start_word(8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                         12'(MAX_PAYLOAD), 8'($urandom)), 1'b0, ERR_NONE);
    repeat (4) begin
      send_word(byte_word(8'($urandom)), 1'b0, ERR_NONE);
    end
    drain_block();

    // Allow any stray late word to show up.
    repeat (8) @(posedge clk_i);
    if (bytes_due.size() != 0) begin
      note_mismatch($sformatf("%0d expected words never came", bytes_due.size()));
    end

    $display("Sent %0d input words: %0d frames opened, %0d misuse words flagged.",
             words_sent, frames_built, misuse_words);
    $display("Checked %0d output words under versions 01, 00, FF and %02h; last frame at %0d bytes.",
             bytes_checked, last_version, MAX_PAYLOAD);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
